### sv/scld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scld_pkg
// Shared types, constants and helpers for the serial command line decoder.
// ----------------------------------------------------------------------------
package scld_pkg;

  // Longest line kept in the count; extra characters are dropped.
  localparam int LINE_MAX   = 31;
  localparam int LEN_W      = $clog2(LINE_MAX + 1);
  // Only positions 0..15 affect any result.
  localparam int KEPT_CHARS = 16;
  localparam int KEPT_W     = $clog2(KEPT_CHARS);

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_REBOOT   = 2'd1,
    KIND_SET_TIME = 2'd2
  } cmd_kind_t;

  typedef logic [KEPT_CHARS-1:0][7:0] line_chars_t;

  // Line store control for one accepted byte.
  typedef struct packed {
    logic       push;   // append byte to line
    logic       flush;  // end of line: clear store
    logic [7:0] data;
  } line_cmd_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } result_t;

  function automatic logic [3:0] digit_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = c - CHAR_ZERO;
    return d[3:0];
  endfunction

  function automatic logic [7:0] bcd_pair(input logic [7:0] hi, input logic [7:0] lo);
    return {digit_nibble(hi), digit_nibble(lo)};
  endfunction

endpackage

### sv/scld_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scld_line_store
// Holds the first characters of the current line and the line length.
// ----------------------------------------------------------------------------
module scld_line_store (
  input  logic                   clk,
  input  logic                   rst_n,
  input  scld_pkg::line_cmd_t    cmd,
  output scld_pkg::line_chars_t  chars
);
  import scld_pkg::*;

  line_chars_t      chars_r;
  line_chars_t      chars_nxt;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;

  always_comb begin
    chars_nxt = chars_r;
    len_nxt   = len_r;
    if (cmd.flush) begin
      chars_nxt = '0;
      len_nxt   = '0;
    end else if (cmd.push && (len_r < LEN_W'(LINE_MAX))) begin
      if (len_r < LEN_W'(KEPT_CHARS)) begin
        chars_nxt[len_r[KEPT_W-1:0]] = cmd.data;
      end
      len_nxt = len_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_r <= '0;
      len_r   <= '0;
    end else begin
      chars_r <= chars_nxt;
      len_r   <= len_nxt;
    end
  end

  assign chars = chars_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(LINE_MAX))
    else $error("line length past LINE_MAX");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> (len_r == '0) && (chars_r == '0))
    else $error("line store not cleared at end of line");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && !cmd.flush && (len_r < LEN_W'(LINE_MAX)))
      |=> (len_r == $past(len_r) + LEN_W'(1)))
    else $error("push did not advance line length");

endmodule

### sv/scld_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scld_decode
// Classifies the stored line and extracts the set-time BCD fields.
// ----------------------------------------------------------------------------
module scld_decode (
  input  scld_pkg::line_chars_t chars,
  output scld_pkg::result_t     result
);
  import scld_pkg::*;

  logic is_reboot;
  logic is_set;

  // A zero byte ends the text for the reboot test.
  assign is_reboot = (chars[0] == CHAR_R) && (chars[1] == CHAR_NUL);
  assign is_set    = (chars[0] == CHAR_S) && (chars[1] == CHAR_COLON);

  always_comb begin
    result = '0;
    if (is_reboot) begin
      result.kind = KIND_REBOOT;
    end else if (is_set) begin
      result.kind   = KIND_SET_TIME;
      result.year   = {bcd_pair(chars[2], chars[3]), bcd_pair(chars[4], chars[5])};
      result.month  = bcd_pair(chars[6], chars[7]);
      result.day    = bcd_pair(chars[8], chars[9]);
      result.hour   = bcd_pair(chars[10], chars[11]);
      result.minute = bcd_pair(chars[12], chars[13]);
      result.second = bcd_pair(chars[14], chars[15]);
    end
  end

endmodule

### sv/serial_command_line_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_line_decoder
// Collects received characters into a line and decodes it at CR or LF into
// a reboot request, a set-time command with BCD date/time, or none.
// ----------------------------------------------------------------------------
//  channel | ports                              | transaction
//  --------+------------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_rx_byte     | one received character
//  out     | out_valid, out_ready, out_bcd_*,   | one decoded line, per CR or LF
//          | out_command_kind                   |
//
//  One byte per cycle sustained while no line terminator waits on a stalled
//  out. A byte is registered in the input register, then it updates the line
//  store or, if it is CR/LF, the stored line is decoded into the result register.
//  Synchronous active-low reset empties the line and both pipeline registers.
//  A stall on out holds only a line terminator in the input register;
//  ordinary characters keep flowing into the line store.
// ----------------------------------------------------------------------------
module serial_command_line_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_command_kind,
  output logic [15:0] out_bcd_year,
  output logic [7:0]  out_bcd_month,
  output logic [7:0]  out_bcd_day,
  output logic [7:0]  out_bcd_hour,
  output logic [7:0]  out_bcd_minute,
  output logic [7:0]  out_bcd_second
);
  import scld_pkg::*;

  // Input register
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_term;
  logic        s1_fire;

  // Result register
  logic        out_valid_r;
  logic        out_valid_nxt;
  result_t     res_r;

  line_chars_t chars;
  line_cmd_t   cmd;
  result_t     decoded;

  assign s1_term = (s1_byte_r == CHAR_CR) || (s1_byte_r == CHAR_LF);

  // A terminator needs room in the result register; other bytes never wait.
  assign s1_fire  = s1_valid_r && (!s1_term || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  assign cmd.push  = s1_fire && !s1_term;
  assign cmd.flush = s1_fire && s1_term;
  assign cmd.data  = s1_byte_r;

  scld_line_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .chars (chars)
  );

  // Decode sees the line as it stands before the terminator clears it.
  scld_decode u_decode (
    .chars  (chars),
    .result (decoded)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.flush) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
    if (cmd.flush) begin
      res_r <= decoded;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_command_kind = res_r.kind;
  assign out_bcd_year     = res_r.year;
  assign out_bcd_month    = res_r.month;
  assign out_bcd_day      = res_r.day;
  assign out_bcd_hour     = res_r.hour;
  assign out_bcd_minute   = res_r.minute;
  assign out_bcd_second   = res_r.second;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.flush)
    else $error("result overwritten while stalled");

  a_plain_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.kind != KIND_SET_TIME))
      |-> (res_r.year == '0) && (res_r.month == '0) && (res_r.day == '0)
          && (res_r.hour == '0) && (res_r.minute == '0) && (res_r.second == '0))
    else $error("time fields set on a non set-time result");

  a_char_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_term) |-> in_ready)
    else $error("ordinary character stalled the input");

endmodule

### tb/sv/scld_line_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scld_line_check_pkg
// Line decoder prediction and result checking for the command line decoder
// testbench.
// ----------------------------------------------------------------------------
package scld_line_check_pkg;
  import scld_pkg::*;

  class line_scoreboard;
    logic [7:0]  line_chars [KEPT_CHARS];
    int unsigned line_len;
    result_t     decoded_q [$];
    int unsigned errors;
    int unsigned n_bytes;
    int unsigned n_results;
    int unsigned n_kind [3];

    function new();
      clear_line();
      errors    = 0;
      n_bytes   = 0;
      n_results = 0;
      foreach (n_kind[k]) n_kind[k] = 0;
    endfunction

    function void clear_line();
      foreach (line_chars[k]) line_chars[k] = CHAR_NUL;
      line_len = 0;
    endfunction

    // Two BCD digits from stored positions pos and pos+1.
    function logic [7:0] digits_at(int unsigned pos);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = line_chars[pos] - CHAR_ZERO;
      lo = line_chars[pos + 1] - CHAR_ZERO;
      return {hi[3:0], lo[3:0]};
    endfunction

    function int unsigned pending();
      return decoded_q.size();
    endfunction

    // Accepted input transaction: extend the line or decode it at CR/LF.
    function void note_byte(logic [7:0] b);
      result_t r;
      n_bytes++;
      if (b != CHAR_CR && b != CHAR_LF) begin
        if (line_len < LINE_MAX) begin
          if (line_len < KEPT_CHARS) line_chars[line_len] = b;
          line_len++;
        end
        return;
      end
      r = '0;
      r.kind = KIND_NONE;
      if (line_chars[0] == CHAR_R && line_chars[1] == CHAR_NUL) begin
        r.kind = KIND_REBOOT;
      end else if (line_chars[0] == CHAR_S && line_chars[1] == CHAR_COLON) begin
        r.kind   = KIND_SET_TIME;
        r.year   = {digits_at(2), digits_at(4)};
        r.month  = digits_at(6);
        r.day    = digits_at(8);
        r.hour   = digits_at(10);
        r.minute = digits_at(12);
        r.second = digits_at(14);
      end
      decoded_q.push_back(r);
      clear_line();
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare_field(string what, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %h, wanted %h", n_results, what, got, want));
    endtask

    // Accepted output transaction against the oldest decoded line.
    task check_result(result_t got);
      result_t want;
      if (decoded_q.size() == 0) begin
        report($sformatf("unexpected result, kind %0d", got.kind));
        return;
      end
      want = decoded_q.pop_front();
      compare_field("command_kind", 16'(got.kind), 16'(want.kind));
      compare_field("bcd_year",     got.year,      want.year);
      compare_field("bcd_month",    16'(got.month),  16'(want.month));
      compare_field("bcd_day",      16'(got.day),    16'(want.day));
      compare_field("bcd_hour",     16'(got.hour),   16'(want.hour));
      compare_field("bcd_minute",   16'(got.minute), 16'(want.minute));
      compare_field("bcd_second",   16'(got.second), 16'(want.second));
      if (want.kind <= KIND_SET_TIME) n_kind[want.kind]++;
      n_results++;
    endtask

    task check_drained();
      if (decoded_q.size() != 0)
        report($sformatf("%0d results never arrived", decoded_q.size()));
    endtask
  endclass

endpackage

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives received bytes into the serial command line decoder, predicts each
// decoded line and checks every result field, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import scld_pkg::*;
  import scld_line_check_pkg::*;

  localparam int RANDOM_BYTES = 1600;
  // Window of the byte stream with neither side idling.
  localparam int CALM_FROM    = 700;
  localparam int CALM_TO      = 1000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_command_kind;
  logic [15:0] out_bcd_year;
  logic [7:0]  out_bcd_month;
  logic [7:0]  out_bcd_day;
  logic [7:0]  out_bcd_hour;
  logic [7:0]  out_bcd_minute;
  logic [7:0]  out_bcd_second;

  line_scoreboard sb;
  logic [7:0]     rx_stream [$];  // every byte to send, directed part first
  bit             calm = 1'b0;    // no idling on either side while set

  serial_command_line_decoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_command_kind (out_command_kind),
    .out_bcd_year     (out_bcd_year),
    .out_bcd_month    (out_bcd_month),
    .out_bcd_day      (out_bcd_day),
    .out_bcd_hour     (out_bcd_hour),
    .out_bcd_minute   (out_bcd_minute),
    .out_bcd_second   (out_bcd_second)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Receiver: ready drops about a quarter of the time, except in the calm window.
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 24);
  end

  // Sample both channels at the rising edge. The result is checked before the
  // input is noted: a line ended in this cycle cannot have its result out yet.
  always @(posedge clk) begin
    result_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.kind   = cmd_kind_t'(out_command_kind);
        got.year   = out_bcd_year;
        got.month  = out_bcd_month;
        got.day    = out_bcd_day;
        got.hour   = out_bcd_hour;
        got.minute = out_bcd_minute;
        got.second = out_bcd_second;
        sb.check_result(got);
      end
      if (in_valid && in_ready) sb.note_byte(in_rx_byte);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------

  function automatic logic [7:0] pick_eol();
    return $urandom_range(1) ? CHAR_CR : CHAR_LF;
  endfunction

  // Any byte that does not end the line, NUL and 8'hFF included.
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CHAR_CR || c == CHAR_LF);
    return c;
  endfunction

  function automatic logic [7:0] digit_char();
    return CHAR_ZERO + 8'($urandom_range(9));
  endfunction

  task automatic push_text(int n);
    repeat (n) rx_stream.push_back(text_char());
  endtask

  // Mostly well-formed commands with random content; the rest is broken
  // prefixes, over-long lines and raw noise that may end lines anywhere.
  task automatic build_random_lines(int target);
    int pick;
    int n;
    while (rx_stream.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        // set time, now and then cut short or with junk in the digits
        rx_stream.push_back(CHAR_S);
        rx_stream.push_back(CHAR_COLON);
        n = ($urandom_range(9) == 0) ? $urandom_range(13) : 14;
        repeat (n)
          rx_stream.push_back(($urandom_range(9) == 0) ? text_char() : digit_char());
        if ($urandom_range(3) == 0) push_text($urandom_range(20));
        rx_stream.push_back(pick_eol());
      end else if (pick < 55) begin
        // reboot; a NUL after the R hides whatever follows
        rx_stream.push_back(CHAR_R);
        if ($urandom_range(2) == 0) begin
          rx_stream.push_back(CHAR_NUL);
          push_text($urandom_range(10));
        end
        rx_stream.push_back(pick_eol());
      end else if (pick < 65) begin
        // long line, often past LINE_MAX; any tail past it is dropped
        if ($urandom_range(1)) begin
          rx_stream.push_back(CHAR_S);
          rx_stream.push_back(CHAR_COLON);
          repeat (14) rx_stream.push_back(digit_char());
          push_text($urandom_range(10, 30));
        end else begin
          push_text($urandom_range(25, 45));
        end
        rx_stream.push_back(pick_eol());
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 20)) rx_stream.push_back(8'($urandom_range(255)));
      end else if (pick < 90) begin
        case ($urandom_range(3))
          0: begin
            rx_stream.push_back(CHAR_S);
            push_text($urandom_range(16));
          end
          1: begin
            rx_stream.push_back(CHAR_R);
            do n = $urandom_range(1, 255); while (n == CHAR_CR || n == CHAR_LF);
            rx_stream.push_back(8'(n));
            push_text($urandom_range(3));
          end
          2: begin
            rx_stream.push_back(8'h73);  // lower-case s
            rx_stream.push_back(CHAR_COLON);
            repeat (14) rx_stream.push_back(digit_char());
          end
          default: ;  // empty line
        endcase
        rx_stream.push_back(pick_eol());
      end else begin
        push_text($urandom_range(20));
        rx_stream.push_back(pick_eol());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Entered right after a falling edge; returns right after one.
  task automatic send_byte(logic [7:0] b);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    int n_directed;
    sb = new();

    // Directed lines: reboot, empty, reboot hidden by NUL, extreme byte
    // values as set-time digits, R followed by more text, a short set time.
    rx_stream = '{CHAR_R, CHAR_CR,
                  CHAR_LF,
                  CHAR_R, CHAR_NUL, CHAR_LF,
                  CHAR_S, CHAR_COLON, 8'hFF, CHAR_NUL, CHAR_CR,
                  CHAR_R, CHAR_S, CHAR_CR,
                  CHAR_S, CHAR_COLON, 8'h32, 8'h30, 8'h32, 8'h34, CHAR_LF};
    n_directed = rx_stream.size();
    build_random_lines(n_directed + RANDOM_BYTES);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rx_stream[k]) begin
      calm = (k >= CALM_FROM && k < CALM_TO);
      send_byte(rx_stream[k]);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Wait for every decoded line, then keep watching for stray results.
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    sb.check_drained();

    $display("sent %0d bytes, checked %0d results: %0d none, %0d reboot, %0d set time",
             sb.n_bytes, sb.n_results, sb.n_kind[KIND_NONE], sb.n_kind[KIND_REBOOT],
             sb.n_kind[KIND_SET_TIME]);
    $display("%0d mismatches", sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
sv/scld_pkg.sv
sv/scld_line_store.sv
sv/scld_decode.sv
sv/serial_command_line_decoder.sv
tb/sv/scld_line_check_pkg.sv
tb/sv/tb_top.sv
